/* design/rid_pkg.sv */
// Package for the radix integer-to-digits printer.
// Widths, character codes, register indexes and the payload and status types.
// No dependencies.
package rid_pkg;

   localparam int VALUE_W           = 32;
   localparam int CHAR_W            = 8;
   localparam int RADIX_W           = 5;
   localparam int NUM_CHARS         = 16;
   localparam int CHAR_IDX_W        = $clog2(NUM_CHARS);
   localparam int DEFAULT_MAX_RADIX = 16;
   localparam int STACK_DEPTH       = 32;
   localparam int STACK_CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int CSR_DATA_W        = 64;
   localparam int CSR_IDX_W         = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_RADIX      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHARS_LOW  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CHARS_HIGH = 2'd2;

   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

   typedef logic [NUM_CHARS-1:0][CHAR_W-1:0] alphabet_type;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               operation;
   } req_type;

   typedef struct packed {
      logic [CHAR_W-1:0] character;
      logic              is_last;
   } rsp_type;

   typedef struct packed {
      logic done;
      logic ok;
   } chk_status_type;

endpackage

/* design/rid_check.sv */
// Alphabet checker: walks the characters one per cycle and flags signs and repeats.
// Depends on rid_pkg.
module rid_check
   import rid_pkg::*;
#(
   parameter int MAX_RADIX = DEFAULT_MAX_RADIX
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [RADIX_W-1:0] radix,
   input  alphabet_type       alphabet,
   output chk_status_type     status
);

   localparam int IDX_W = (MAX_RADIX > 1) ? $clog2(MAX_RADIX) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_RADIX - 1);

   logic              busy_ff, busy_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              bad_ff, bad_in;
   chk_status_type    status_ff, status_in;
   logic [CHAR_W-1:0] cur_char;
   logic              in_use;
   logic              hit;

   always_comb begin
      cur_char = alphabet[CHAR_IDX_W'(idx_ff)];
      in_use   = RADIX_W'(idx_ff) < radix;
      hit      = (cur_char == CHAR_PLUS) || (cur_char == CHAR_MINUS);
      for (int j = 0; j < NUM_CHARS; j++) begin
         if ((RADIX_W'(j) > RADIX_W'(idx_ff)) && (RADIX_W'(j) < radix)
             && (alphabet[j] == cur_char)) begin
            hit = 1'b1;
         end
      end
   end

   always_comb begin
      busy_in   = busy_ff;
      idx_in    = idx_ff;
      bad_in    = bad_ff;
      status_in = '{done: 1'b0, ok: 1'b0};
      if (start) begin
         busy_in = 1'b1;
         idx_in  = '0;
         bad_in  = (radix < RADIX_W'(2)) || (radix > RADIX_W'(MAX_RADIX));
      end else if (busy_ff) begin
         bad_in = bad_ff || (in_use && hit);
         idx_in = idx_ff + 1'b1;
         if (idx_ff == LAST_IDX) begin
            busy_in   = 1'b0;
            status_in = '{done: 1'b1, ok: !bad_in};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         status_ff <= '{done: 1'b0, ok: 1'b0};
      end else begin
         busy_ff   <= busy_in;
         status_ff <= status_in;
      end
      idx_ff <= idx_in;
      bad_ff <= bad_in;
   end

   assign status = status_ff;

`ifndef SYNTHESIS
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      status_ff.done |-> $past(busy_ff))
      else $error("checker finished without running");
`endif

endmodule

/* design/rid_div.sv */
// Bit-serial restoring divider: one quotient bit per cycle, divisor is the radix.
// Depends on rid_pkg.
module rid_div
   import rid_pkg::*;
#(
   parameter int MAX_RADIX = DEFAULT_MAX_RADIX
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [VALUE_W-1:0]           dividend,
   input  logic [RADIX_W-1:0]           radix,
   output logic                         done,
   output logic [VALUE_W-1:0]           quotient,
   output logic [$clog2(MAX_RADIX)-1:0] digit
);

   localparam int DIGIT_W = $clog2(MAX_RADIX);
   localparam int REM_W   = DIGIT_W + 1;
   localparam int CNT_W   = $clog2(VALUE_W);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [VALUE_W-1:0] quo_ff, quo_in;
   logic [REM_W-1:0]   rem_ff, rem_in;
   logic [REM_W-1:0]   shifted;
   logic [REM_W-1:0]   divisor;
   logic               qbit;

   always_comb begin
      divisor = radix[REM_W-1:0];
      shifted = {rem_ff[REM_W-2:0], quo_ff[VALUE_W-1]};
      qbit    = shifted >= divisor;
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in = qbit ? (shifted - divisor) : shifted;
         quo_in = {quo_ff[VALUE_W-2:0], qbit};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(VALUE_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
   assign digit    = rem_ff[DIGIT_W-1:0];

`ifndef SYNTHESIS
   a_start_when_free: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider restarted while busy");
`endif

endmodule

/* design/rid_stack.sv */
// Digit stack: shift register, pushed least significant digit first, popped from the top.
// Depends on rid_pkg.
module rid_stack
   import rid_pkg::*;
#(
   parameter int DIGIT_W = $clog2(DEFAULT_MAX_RADIX)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   clear,
   input  logic                   push,
   input  logic                   pop,
   input  logic [DIGIT_W-1:0]     din,
   output logic [DIGIT_W-1:0]     top_digit,
   output logic [STACK_CNT_W-1:0] count
);

   logic [DIGIT_W-1:0]     digits_ff [STACK_DEPTH];
   logic [DIGIT_W-1:0]     digits_in [STACK_DEPTH];
   logic [STACK_CNT_W-1:0] count_ff, count_in;

   always_comb begin
      digits_in = digits_ff;
      count_in  = count_ff;
      if (clear) begin
         count_in = '0;
      end else if (push) begin
         digits_in[0] = din;
         for (int k = 1; k < STACK_DEPTH; k++) begin
            digits_in[k] = digits_ff[k-1];
         end
         count_in = count_ff + 1'b1;
      end else if (pop) begin
         for (int k = 0; k < STACK_DEPTH - 1; k++) begin
            digits_in[k] = digits_ff[k+1];
         end
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      digits_ff <= digits_in;
   end

   assign top_digit = digits_ff[0];
   assign count     = count_ff;

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (push && !clear) |-> (count_ff != STACK_CNT_W'(STACK_DEPTH)))
      else $error("digit stack overflow");
`endif

endmodule

/* design/radix_integer_to_digits.sv */
// Top level of the radix integer-to-digits printer.
// Depends on rid_pkg, rid_check, rid_div and rid_stack.
//
// Usage:
//   req channel: one transfer carries a 32-bit value and an operation bit
//   (0 signed, 1 unsigned). rsp channel: one transfer per output character,
//   a leading '-' for negative signed values, then the digits most
//   significant first; is_last marks the final character.
//   csr port: radix (index 0), characters 0..7 (index 1) and 8..15 (index 2),
//   written on any cycle with csr_write high; write only while idle.
// Per item: the alphabet check runs first, then the bit-serial divider produces
//   one digit per division, and then one character per cycle is emitted while
//   rsp_ready is high. An invalid alphabet ends the item with no output.
// req_ready is high only between items; the last character may still sit in
//   the output register while the next item is taken. A stalled receiver
//   holds the output register and pauses character emission.
// Reset clears the radix and character registers to zero, so the alphabet is invalid until
//   radix and the characters are written.
module radix_integer_to_digits
   import rid_pkg::*;
#(
   parameter int MAX_RADIX = DEFAULT_MAX_RADIX
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_payload,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int DIGIT_W = $clog2(MAX_RADIX);

   typedef enum logic [1:0] {ST_IDLE, ST_CHECK, ST_DIV, ST_EMIT} state_type;

   state_type          state_ff, state_in;
   logic [VALUE_W-1:0] mag_ff, mag_in;
   logic               sign_ff, sign_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic [RADIX_W-1:0]    radix_ff;
   logic [CSR_DATA_W-1:0] chars_low_ff;
   logic [CSR_DATA_W-1:0] chars_high_ff;
   alphabet_type          alphabet;

   chk_status_type         chk_status;
   logic                   chk_start;
   logic                   div_start;
   logic [VALUE_W-1:0]     div_dividend;
   logic                   div_done;
   logic [VALUE_W-1:0]     div_quotient;
   logic [DIGIT_W-1:0]     div_digit;
   logic                   stk_clear;
   logic                   stk_push;
   logic                   stk_pop;
   logic [DIGIT_W-1:0]     stk_top;
   logic [STACK_CNT_W-1:0] stk_count;
   logic                   is_neg;

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff      <= '0;
         chars_low_ff  <= '0;
         chars_high_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_RADIX:      radix_ff      <= csr_wdata[RADIX_W-1:0];
            CSR_CHARS_LOW:  chars_low_ff  <= csr_wdata;
            CSR_CHARS_HIGH: chars_high_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign alphabet = {chars_high_ff, chars_low_ff};

   rid_check #(.MAX_RADIX(MAX_RADIX)) u_check (
      .clock    (clock),
      .reset    (reset),
      .start    (chk_start),
      .radix    (radix_ff),
      .alphabet (alphabet),
      .status   (chk_status)
   );

   rid_div #(.MAX_RADIX(MAX_RADIX)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .radix    (radix_ff),
      .done     (div_done),
      .quotient (div_quotient),
      .digit    (div_digit)
   );

   rid_stack #(.DIGIT_W(DIGIT_W)) u_stack (
      .clock     (clock),
      .reset     (reset),
      .clear     (stk_clear),
      .push      (stk_push),
      .pop       (stk_pop),
      .din       (div_digit),
      .top_digit (stk_top),
      .count     (stk_count)
   );

   always_comb begin
      state_in     = state_ff;
      mag_in       = mag_ff;
      sign_in      = sign_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      chk_start    = 1'b0;
      div_start    = 1'b0;
      div_dividend = mag_ff;
      stk_clear    = 1'b0;
      stk_push     = 1'b0;
      stk_pop      = 1'b0;
      is_neg       = !req_payload.operation && req_payload.value[VALUE_W-1];
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               stk_clear = 1'b1;
               chk_start = 1'b1;
               sign_in   = is_neg;
               mag_in    = is_neg ? (VALUE_W'(0) - req_payload.value) : req_payload.value;
               state_in  = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (chk_status.done) begin
               if (chk_status.ok) begin
                  div_start = 1'b1;
                  state_in  = ST_DIV;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               stk_push = 1'b1;
               if (div_quotient != '0) begin
                  div_start    = 1'b1;
                  div_dividend = div_quotient;
               end else begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               if (sign_ff) begin
                  rsp_in  = '{character: CHAR_MINUS, is_last: 1'b0};
                  sign_in = 1'b0;
               end else begin
                  stk_pop = 1'b1;
                  rsp_in  = '{character: alphabet[CHAR_IDX_W'(stk_top)],
                              is_last:   stk_count == STACK_CNT_W'(1)};
                  if (stk_count == STACK_CNT_W'(1)) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sign_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sign_ff      <= sign_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mag_ff <= mag_in;
      rsp_ff <= rsp_in;
   end

   assign req_ready   = state_ff == ST_IDLE;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTHESIS
   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.character == CHAR_MINUS) |-> !rsp_ff.is_last)
      else $error("sign transfer flagged as last");

   a_emit_has_digits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (stk_count != '0))
      else $error("emitting with an empty digit stack");

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV))
      else $error("divider result outside the divide phase");
`endif

endmodule

/* bench/testbench.sv */
// Self-checking bench for radix_integer_to_digits: directed and random numbers
// through the req/rsp channels, expected characters held in a queue.
// Depends on rid_pkg and the radix_integer_to_digits design files.
`timescale 1ns / 1ps

module testbench;
   import rid_pkg::*;

   localparam int MAX_RADIX     = DEFAULT_MAX_RADIX;
   localparam int IDLE_PCT      = 20;
   localparam int HOLD_CYCLES   = 2500;
   localparam int SETTLE_CYCLES = 64;
   localparam int TAIL_CYCLES   = 1200;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef enum logic {
      OP_SIGNED   = 1'b0,
      OP_UNSIGNED = 1'b1
   } op_kind_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_type               req_payload;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_type               rsp_payload;
   logic                  csr_write;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   logic [RADIX_W-1:0] radix_cfg;
   alphabet_type       alphabet_cfg;
   rsp_type            pending_chars[$];
   int                 mismatches;
   bit                 no_idle;
   bit                 stall_request;

   radix_integer_to_digits #(
      .MAX_RADIX(MAX_RADIX)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic bit alphabet_ok();
      if (radix_cfg < 2 || radix_cfg > MAX_RADIX) return 1'b0;
      for (int i = 0; i < radix_cfg; i++) begin
         if (alphabet_cfg[i] == CHAR_PLUS || alphabet_cfg[i] == CHAR_MINUS) return 1'b0;
         for (int j = i + 1; j < radix_cfg; j++)
            if (alphabet_cfg[i] == alphabet_cfg[j]) return 1'b0;
      end
      return 1'b1;
   endfunction

   // Expected characters of one number, sign first, digits most significant first
   function automatic void format_number(req_type item);
      logic [VALUE_W-1:0] mag;
      logic [CHAR_W-1:0]  digits[$];
      rsp_type            ch;
      if (!alphabet_ok()) return;
      mag = item.value;
      if (item.operation == OP_SIGNED && item.value[VALUE_W-1]) begin
         mag = 32'd0 - item.value;
         ch.character = CHAR_MINUS;
         ch.is_last   = 1'b0;
         pending_chars.push_back(ch);
      end
      do begin
         digits.push_front(alphabet_cfg[mag % radix_cfg]);
         mag = mag / radix_cfg;
      end while (mag != 0);
      foreach (digits[k]) begin
         ch.character = digits[k];
         ch.is_last   = (k == digits.size() - 1);
         pending_chars.push_back(ch);
      end
   endfunction

   function automatic alphabet_type random_alphabet();
      bit                used[256];
      logic [CHAR_W-1:0] c;
      alphabet_type      chars;
      for (int k = 0; k < NUM_CHARS; k++) begin
         do c = CHAR_W'($urandom_range(0, 255));
         while (used[c] || c == CHAR_PLUS || c == CHAR_MINUS);
         used[c]  = 1'b1;
         chars[k] = c;
      end
      return chars;
   endfunction

   function automatic alphabet_type decimal_alphabet();
      alphabet_type chars;
      chars = '0;
      for (int k = 0; k < 10; k++) chars[k] = 8'h30 + CHAR_W'(k);
      return chars;
   endfunction

   function automatic logic [VALUE_W-1:0] random_value();
      logic [VALUE_W-1:0] corners[4] = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF};
      case ($urandom_range(0, 7))
         0, 1: begin
            return $urandom_range(0, 300);
         end
         2: begin
            return 32'd0 - $urandom_range(0, 300);
         end
         3: begin
            return corners[$urandom_range(0, 3)] ^ $urandom_range(0, 3);
         end
         default: begin
            return $urandom;
         end
      endcase
   endfunction

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_RADIX: begin
            radix_cfg = data[RADIX_W-1:0];
         end
         CSR_CHARS_LOW: begin
            alphabet_cfg[7:0] = data;
         end
         CSR_CHARS_HIGH: begin
            alphabet_cfg[15:8] = data;
         end
         default: ;
      endcase
   endtask

   task automatic load_alphabet(input logic [RADIX_W-1:0] r, input alphabet_type chars);
      logic [CSR_DATA_W-1:0] data;
      data = {$urandom, $urandom};
      data[RADIX_W-1:0] = r;
      write_register(CSR_RADIX, data);
      write_register(CSR_CHARS_LOW, chars[7:0]);
      write_register(CSR_CHARS_HIGH, chars[15:8]);
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   // Leaves req_valid high after the transfer; wait_idle drops it
   task automatic send_number(input logic [VALUE_W-1:0] v, input op_kind_type op);
      req_type item;
      item.value     = v;
      item.operation = op;
      if (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
      format_number(item);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_chars.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic test_reset_state();
      send_number(32'd7, OP_UNSIGNED);
      send_number(32'hFFFF_FFFF, OP_SIGNED);
      wait_idle();
   endtask

   task automatic test_decimal();
      load_alphabet(5'd10, decimal_alphabet());
      send_number(32'd0, OP_SIGNED);
      send_number(32'd1, OP_UNSIGNED);
      send_number(32'hFFFF_FFFF, OP_SIGNED);
      send_number(32'hFFFF_FFFF, OP_UNSIGNED);
      send_number(32'h8000_0000, OP_SIGNED);
      send_number(32'h8000_0000, OP_UNSIGNED);
      send_number(32'h7FFF_FFFF, OP_SIGNED);
      send_number(32'd12345, OP_SIGNED);
      wait_idle();
   endtask

   // zero byte as digit 0; unused characters all zero too
   task automatic test_binary_zero_char();
      alphabet_type chars;
      chars    = '0;
      chars[1] = 8'hFF;
      load_alphabet(5'd2, chars);
      send_number(32'hFFFF_FFFF, OP_UNSIGNED);
      send_number(32'h8000_0000, OP_SIGNED);
      send_number(32'd0, OP_UNSIGNED);
      wait_idle();
   endtask

   task automatic test_hex();
      load_alphabet(RADIX_W'(MAX_RADIX), random_alphabet());
      send_number(32'hDEAD_BEEF, OP_UNSIGNED);
      send_number(32'hFEDC_BA98, OP_SIGNED);
      send_number(32'h0123_4567, OP_SIGNED);
      wait_idle();
   endtask

   task automatic test_invalid_alphabets();
      alphabet_type chars;
      logic [RADIX_W-1:0] bad_radix[3] = '{5'd1, RADIX_W'(MAX_RADIX + 1), 5'd31};
      foreach (bad_radix[k]) begin
         load_alphabet(bad_radix[k], random_alphabet());
         send_number(32'hFFFF_FF00, OP_SIGNED);
         wait_idle();
      end
      chars = random_alphabet();
      chars[9] = chars[4];
      load_alphabet(5'd10, chars);
      send_number(32'd99, OP_UNSIGNED);
      wait_idle();
      chars = decimal_alphabet();
      chars[$urandom_range(0, 9)] = CHAR_PLUS;
      load_alphabet(5'd10, chars);
      send_number(32'd42, OP_SIGNED);
      wait_idle();
      chars = decimal_alphabet();
      chars[$urandom_range(0, 9)] = CHAR_MINUS;
      load_alphabet(5'd10, chars);
      send_number(32'hFFFF_FFD6, OP_SIGNED);
      wait_idle();
   endtask

   task automatic test_unknown_register();
      load_alphabet(5'd10, decimal_alphabet());
      write_register(CSR_UNUSED, {$urandom, $urandom});
      csr_write <= 1'b0;
      @(posedge clock);
      send_number(32'hFFFF_FFFB, OP_SIGNED);
      wait_idle();
   endtask

   // receiver holds off while binary numbers keep coming
   task automatic test_receiver_hold();
      load_alphabet(5'd2, random_alphabet());
      no_idle       = 1'b1;
      stall_request = 1'b1;
      repeat (8) send_number(random_value(), op_kind_type'($urandom_range(0, 1)));
      no_idle = 1'b0;
      wait_idle();
   endtask

   task automatic test_random();
      alphabet_type       chars;
      logic [RADIX_W-1:0] r;
      int                 i;
      int                 j;
      int                 count;
      for (int phase = 0; phase < 12; phase++) begin
         chars = random_alphabet();
         r     = RADIX_W'($urandom_range(2, MAX_RADIX));
         count = $urandom_range(12, 22);
         case ($urandom_range(0, 11))
            0: begin
               r = RADIX_W'($urandom_range(0, 1));
            end
            1: begin
               r = RADIX_W'($urandom_range(MAX_RADIX + 1, 31));
            end
            2: begin
               i = $urandom_range(0, r - 2);
               j = $urandom_range(i + 1, r - 1);
               chars[j] = chars[i];
            end
            3: begin
               chars[$urandom_range(0, r - 1)] = $urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS;
            end
            default: ;
         endcase
         load_alphabet(r, chars);
         if (!alphabet_ok()) count = 4;
         no_idle = (phase == 5);
         repeat (count) send_number(random_value(), op_kind_type'($urandom_range(0, 1)));
         no_idle = 1'b0;
         wait_idle();
      end
   endtask

   initial begin
      forever begin
         @(posedge clock);
         if (stall_request) begin
            stall_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_ready <= no_idle || $urandom_range(0, 99) >= IDLE_PCT;
      end
   end

   always @(posedge clock) begin : check_chars
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_chars.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected character, expected none actual %h last %b",
                     $time, rsp_payload.character, rsp_payload.is_last);
         end else begin
            want = pending_chars.pop_front();
            if (rsp_payload.character !== want.character) begin
               mismatches++;
               $display("%0t: character mismatch, expected %h actual %h",
                        $time, want.character, rsp_payload.character);
            end
            if (rsp_payload.is_last !== want.is_last) begin
               mismatches++;
               $display("%0t: is_last mismatch, expected %b actual %b",
                        $time, want.is_last, rsp_payload.is_last);
            end
         end
      end
   end

   initial begin
      #15_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_payload   = '0;
      rsp_ready     = 1'b0;
      csr_write     = 1'b0;
      csr_index     = CSR_RADIX;
      csr_wdata     = '0;
      radix_cfg     = '0;
      alphabet_cfg  = '0;
      mismatches    = 0;
      no_idle       = 1'b0;
      stall_request = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_state();
      test_decimal();
      test_binary_zero_char();
      test_hex();
      test_invalid_alphabets();
      test_unknown_register();
      test_receiver_hold();
      test_random();

      while (pending_chars.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

/* filelist.f */
design/rid_pkg.sv
design/rid_check.sv
design/rid_div.sv
design/rid_stack.sv
design/radix_integer_to_digits.sv
bench/testbench.sv
